/* hw/rtl/generational_handle_allocator_core_macros.svh */
// Assertion macros used by the handle allocator checker.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_CORE_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/gha_pkg.sv */
// Types, codes and constants of the generational handle allocator.
`default_nettype none

package gha_pkg;

  localparam int unsigned SlotsDefault = 256;
  localparam int unsigned QueueDepth   = 2;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned IndexW  = 9;
  localparam int unsigned GenW    = 16;
  localparam int unsigned StatusW = 2;

  localparam logic [GenW-1:0] GenTop = 16'hFFFF;

  localparam logic [FuncW-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FuncW-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FuncW-1:0] FUNC_CHECK = 2'd2;

  localparam logic [StatusW-1:0] ST_OK      = 2'd0;
  localparam logic [StatusW-1:0] ST_INVALID = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL    = 2'd2;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_CHECK,
    OP_REJECT
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [IndexW-1:0] idx;
    logic [GenW-1:0]   gen;
  } req_t;

endpackage

`default_nettype wire

/* hw/rtl/generational_handle_allocator_core.sv */
// Flow: a request passes the queue, then the back end's S_IDLE, S_FIFO for an
//   allocate that finds a free slot, and S_EXEC, which loads the result register.
// Issue: the back end takes a new request only once back in S_IDLE, the queue holds
//   later ones; the slot table's read-then-write and the free-ring read set this.
// Reset: control, ring pointers and high-water mark clear and the free count loads Slots
//   at once; the tables are never swept, their unwritten entries read as their start values.
`default_nettype none

module generational_handle_allocator_core import gha_pkg::*; #(
  parameter int unsigned Slots = SlotsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [FuncW-1:0]   func_i,
  input  logic [IndexW-1:0]  handle_index_i,
  input  logic [GenW-1:0]    handle_generation_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [StatusW-1:0] status_o,
  output logic [IndexW-1:0]  out_index_o,
  output logic [GenW-1:0]    out_generation_o,
  output logic               retired_o
);

  req_t push_req, head_req;
  logic push, pop, q_full, q_empty;

  gha_front #(.Slots(Slots)) u_front (
    .in_valid_i          (in_valid_i),
    .func_i              (func_i),
    .handle_index_i      (handle_index_i),
    .handle_generation_i (handle_generation_i),
    .q_full_i            (q_full),
    .in_stall_o          (in_stall_o),
    .q_push_o            (push),
    .q_req_o             (push_req)
  );

  gha_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (push_req),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .req_o   (head_req)
  );

  gha_back #(.Slots(Slots)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_req_i          (head_req),
    .q_pop_o          (pop),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .out_index_o      (out_index_o),
    .out_generation_o (out_generation_o),
    .retired_o        (retired_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/gha_front.sv */
// Front end: takes requests and classifies them by function and index range.
`default_nettype none

module gha_front import gha_pkg::*; #(
  parameter int unsigned Slots = SlotsDefault
) (
  input  logic              in_valid_i,
  input  logic [FuncW-1:0]  func_i,
  input  logic [IndexW-1:0] handle_index_i,
  input  logic [GenW-1:0]   handle_generation_i,
  input  logic              q_full_i,
  output logic              in_stall_o,
  output logic              q_push_o,
  output req_t              q_req_o
);

  logic in_range;

  assign in_range = (handle_index_i != '0) && (32'(handle_index_i) <= Slots);

  always_comb begin
    q_req_o.idx = handle_index_i;
    q_req_o.gen = handle_generation_i;
    unique case (func_i)
      FUNC_ALLOC: q_req_o.op = OP_ALLOC;
      FUNC_FREE:  q_req_o.op = in_range ? OP_FREE : OP_REJECT;
      FUNC_CHECK: q_req_o.op = in_range ? OP_CHECK : OP_REJECT;
      default:    q_req_o.op = OP_REJECT;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

`default_nettype wire

/* hw/rtl/gha_queue.sv */
// Short request queue between the front end and the back end.
`default_nettype none

module gha_queue import gha_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t req_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output req_t req_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  req_t            entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign req_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/gha_back.sv */
// Back end: slot table, free-slot ring and result register.
`default_nettype none

module gha_back import gha_pkg::*; #(
  parameter int unsigned Slots = SlotsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  req_t               q_req_i,
  output logic               q_pop_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [StatusW-1:0] status_o,
  output logic [IndexW-1:0]  out_index_o,
  output logic [GenW-1:0]    out_generation_o,
  output logic               retired_o
);

  localparam int unsigned IdxW = $clog2(Slots);
  localparam int unsigned CntW = $clog2(Slots + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIFO = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  typedef struct packed {
    logic            live;
    logic [GenW-1:0] gen;
  } slot_t;

  // Memories
  slot_t           slot_mem [Slots];
  logic [IdxW-1:0] fifo_mem [Slots];
  slot_t           slot_rd_q;
  logic [IdxW-1:0] fifo_rd_q;
  logic            fifo_ok_q;

  // Control state
  logic [1:0]      state_q, state_d;
  req_t            cur_q, cur_d;
  logic            full_q, full_d;
  logic [IdxW-1:0] slot_q, slot_d;
  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d;
  logic            tail_wrap_q, tail_wrap_d;
  logic [CntW-1:0] free_cnt_q, free_cnt_d;
  logic [CntW-1:0] hw_q, hw_d;

  // Result register
  logic               out_valid_q;
  logic [StatusW-1:0] status_q, status_d;
  logic [IndexW-1:0]  index_q, index_d;
  logic [GenW-1:0]    gen_q, gen_d;
  logic               retired_q, retired_d;

  // Memory ports
  logic            slot_re, slot_we;
  logic [IdxW-1:0] slot_raddr;
  slot_t           slot_wdata;
  logic            fifo_re, fifo_we;

  logic            out_free, exec_go;
  logic [IdxW-1:0] q_slot, fifo_slot;
  logic            slot_init, hit, at_top;
  slot_t           rd_eff;
  logic [CntW-1:0] slot_p1;

  function automatic logic [IdxW-1:0] ptr_inc(logic [IdxW-1:0] p);
    ptr_inc = (p == IdxW'(Slots - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_free  = !out_valid_q || !out_stall_i;
  assign exec_go   = (state_q == S_EXEC) && out_free;
  assign q_pop_o   = (state_q == S_IDLE) && !q_empty_i;
  assign q_slot    = IdxW'(32'(q_req_i.idx) - 32'd1);
  assign fifo_slot = fifo_ok_q ? fifo_rd_q : head_q;

  // Slots at or above the high-water mark were never written: read as zero.
  assign slot_init = CntW'(slot_q) < hw_q;
  assign rd_eff    = slot_init ? slot_rd_q : '0;
  assign hit       = rd_eff.live && (rd_eff.gen == cur_q.gen);
  assign at_top    = (rd_eff.gen == GenTop);
  assign slot_p1   = CntW'(slot_q) + CntW'(1);

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    full_d      = full_q;
    slot_d      = slot_q;
    head_d      = head_q;
    tail_d      = tail_q;
    tail_wrap_d = tail_wrap_q;
    free_cnt_d  = free_cnt_q;
    hw_d        = hw_q;
    slot_re     = 1'b0;
    slot_raddr  = q_slot;
    slot_we     = 1'b0;
    slot_wdata  = rd_eff;
    fifo_re     = 1'b0;
    fifo_we     = 1'b0;
    status_d    = ST_INVALID;
    index_d     = '0;
    gen_d       = '0;
    retired_d   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          cur_d  = q_req_i;
          slot_d = q_slot;
          full_d = (free_cnt_q == '0);
          if (q_req_i.op == OP_ALLOC && free_cnt_q != '0) begin
            fifo_re = 1'b1;
            state_d = S_FIFO;
          end else begin
            slot_re = (q_req_i.op == OP_FREE) || (q_req_i.op == OP_CHECK);
            state_d = S_EXEC;
          end
        end
      end
      S_FIFO: begin
        // Pop the ring head, fetch the slot it names.
        slot_d     = fifo_slot;
        slot_re    = 1'b1;
        slot_raddr = fifo_slot;
        head_d     = ptr_inc(head_q);
        free_cnt_d = free_cnt_q - 1'b1;
        state_d    = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
          case (cur_q.op) inside
            OP_ALLOC: begin
              if (full_q) begin
                status_d = ST_FULL;
              end else begin
                status_d   = ST_OK;
                index_d    = IndexW'(slot_p1);
                gen_d      = rd_eff.gen;
                slot_we    = 1'b1;
                slot_wdata = '{live: 1'b1, gen: rd_eff.gen};
                if (!slot_init) begin
                  hw_d = slot_p1;
                end
              end
            end
            OP_FREE, OP_CHECK: begin
              if (hit) begin
                status_d = ST_OK;
                index_d  = IndexW'(slot_p1);
                gen_d    = rd_eff.gen;
                if (cur_q.op == OP_FREE) begin
                  slot_we    = 1'b1;
                  slot_wdata = '{live: 1'b0, gen: at_top ? rd_eff.gen : rd_eff.gen + 1'b1};
                  retired_d  = at_top;
                  if (!at_top) begin
                    fifo_we    = 1'b1;
                    tail_d     = ptr_inc(tail_q);
                    free_cnt_d = free_cnt_q + 1'b1;
                    if (tail_q == IdxW'(Slots - 1)) begin
                      tail_wrap_d = 1'b1;
                    end
                  end
                end
              end
            end
            default: begin
              status_d = ST_INVALID;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_q] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem[slot_raddr];
    end
    if (fifo_we) begin
      fifo_mem[tail_q] <= slot_q;
    end
    if (fifo_re) begin
      fifo_rd_q <= fifo_mem[head_q];
      // Ring entries the tail has not yet reached still hold their own index.
      fifo_ok_q <= tail_wrap_q || (head_q < tail_q);
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    full_q <= full_d;
    slot_q <= slot_d;
    if (exec_go) begin
      status_q  <= status_d;
      index_q   <= index_d;
      gen_q     <= gen_d;
      retired_q <= retired_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      tail_wrap_q <= 1'b0;
      free_cnt_q  <= CntW'(Slots);
      hw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      tail_wrap_q <= tail_wrap_d;
      free_cnt_q  <= free_cnt_d;
      hw_q        <= hw_d;
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign out_index_o      = index_q;
  assign out_generation_o = gen_q;
  assign retired_o        = retired_q;

endmodule

`default_nettype wire

/* hw/rtl/gha_checker.sv */
// Port-level checker for the handle allocator, bound to the top level.
`default_nettype none
`include "generational_handle_allocator_core_macros.svh"

module gha_checker import gha_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [StatusW-1:0] status_o,
  input logic [IndexW-1:0]  out_index_o,
  input logic [GenW-1:0]    out_generation_o,
  input logic               retired_o
);

  `GHA_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(out_index_o) && $stable(out_generation_o) && $stable(retired_o), "stalled result changed")
  `GHA_ASSERT_IMP(a_ok_index, out_valid_o && status_o == ST_OK, out_index_o != '0, "ok result with null index")
  `GHA_ASSERT_IMP(a_fail_zero, out_valid_o && status_o != ST_OK, out_index_o == '0 && out_generation_o == '0 && !retired_o, "failed result carries data")
  `GHA_ASSERT_IMP(a_retire_top, out_valid_o && retired_o, status_o == ST_OK && out_generation_o == GenTop, "retire below top generation")

endmodule

bind generational_handle_allocator_core gha_checker u_checker (.*);

`default_nettype wire

/* test/generational_handle_allocator_core_test.sv */
// Self-checking testbench of the generational handle allocator core.
module generational_handle_allocator_core_test;
  import gha_pkg::*;

  localparam int unsigned Slots = SlotsDefault;
  localparam logic [FuncW-1:0] FUNC_SPARE = 2'd3;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomRequests = 180;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IndexW-1:0]  idx;
    logic [GenW-1:0]    gen;
    logic               retired;
  } handle_outcome_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [FuncW-1:0]   func_i = FUNC_ALLOC;
  logic [IndexW-1:0]  handle_index_i = '0;
  logic [GenW-1:0]    handle_generation_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [StatusW-1:0] status_o;
  logic [IndexW-1:0]  out_index_o;
  logic [GenW-1:0]    out_generation_o;
  logic               retired_o;

  // Predicted slot table and free ring
  bit                slot_live [Slots];
  bit [GenW-1:0]     slot_gen  [Slots];
  int unsigned       free_ring [Slots];
  int unsigned       ring_head = 0;
  int unsigned       ring_tail = 0;
  int unsigned       free_slots = Slots;

  handle_outcome_t   awaited_outcomes [$];
  int unsigned       errors = 0;
  int unsigned       burst_left = 0;
  bit                request_held = 1'b0;
  bit                steady_flow = 1'b0;
  int unsigned       quiet_cycles = 0;
  stall_style_e      stall_style = STALL_NONE;
  int unsigned       stall_run = 0;
  logic [3:0]        stall_phase = '0;

  generational_handle_allocator_core #(
    .Slots(Slots)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .func_i,
    .handle_index_i,
    .handle_generation_i,
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .out_index_o,
    .out_generation_o,
    .retired_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic handle_outcome_t allocator_outcome(input logic [FuncW-1:0] f,
                                                        input logic [IndexW-1:0] idx,
                                                        input logic [GenW-1:0] gen);
    handle_outcome_t res;
    int unsigned slot;
    res = '0;
    res.status = ST_INVALID;
    if (f == FUNC_ALLOC) begin
      if (free_slots == 0) begin
        res.status = ST_FULL;
      end else begin
        slot = free_ring[ring_head];
        ring_head = (ring_head + 1) % Slots;
        free_slots--;
        slot_live[slot] = 1'b1;
        res.status = ST_OK;
        res.idx = IndexW'(slot + 1);
        res.gen = slot_gen[slot];
      end
    end else if ((f == FUNC_FREE || f == FUNC_CHECK) && idx != 0 && idx <= Slots) begin
      slot = idx - 1;
      if (slot_live[slot] && slot_gen[slot] == gen) begin
        res.status = ST_OK;
        res.idx = idx;
        res.gen = slot_gen[slot];
        if (f == FUNC_FREE) begin
          slot_live[slot] = 1'b0;
          // a slot at the top generation is retired, never requeued
          if (slot_gen[slot] == GenTop) begin
            res.retired = 1'b1;
          end else begin
            slot_gen[slot] = slot_gen[slot] + 1'b1;
            free_ring[ring_tail] = slot;
            ring_tail = (ring_tail + 1) % Slots;
            free_slots++;
          end
        end
      end
    end
    return res;
  endfunction

  // Zero-based live slot from a random start, or Slots when none is live.
  function automatic int unsigned pick_live_slot();
    int unsigned start;
    start = $urandom_range(0, Slots - 1);
    for (int k = 0; k < Slots; k++) begin
      if (slot_live[(start + k) % Slots]) return (start + k) % Slots;
    end
    return Slots;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got %0h want %0h", what, got, want);
    errors++;
  endtask

  task automatic send_request(input logic [FuncW-1:0] f, input logic [IndexW-1:0] idx,
                              input logic [GenW-1:0] gen);
    int unsigned gap;
    if (!steady_flow && burst_left == 0) begin
      gap = $urandom_range(0, 5);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      if (gap != 0 && request_held) begin
        in_valid_i <= 1'b0;
        request_held = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left != 0) burst_left--;
    in_valid_i <= 1'b1;
    func_i <= f;
    handle_index_i <= idx;
    handle_generation_i <= gen;
    request_held = 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    awaited_outcomes.push_back(allocator_outcome(f, idx, gen));
  endtask

  task automatic wait_drained();
    if (request_held) begin
      in_valid_i <= 1'b0;
      request_held = 1'b0;
    end
    do @(posedge clk_i); while (awaited_outcomes.size() != 0);
  endtask

  task automatic test_bad_handles();
    send_request(FUNC_CHECK, '0, '0);
    send_request(FUNC_FREE, '0, GenTop);
    send_request(FUNC_CHECK, 9'd257, '0);
    send_request(FUNC_FREE, 9'h1FF, GenTop);
    send_request(FUNC_CHECK, 9'd1, '0);
    send_request(FUNC_CHECK, 9'd256, '0);
    send_request(FUNC_SPARE, 9'h1FF, GenTop);
    send_request(FUNC_SPARE, '0, '0);
    wait_drained();
  endtask

  task automatic test_lifecycle();
    repeat (3) send_request(FUNC_ALLOC, '0, '0);
    send_request(FUNC_CHECK, 9'd2, '0);
    send_request(FUNC_CHECK, 9'd2, 16'd1);
    send_request(FUNC_FREE, 9'd2, 16'h8000);
    send_request(FUNC_FREE, 9'd2, '0);
    send_request(FUNC_FREE, 9'd2, '0);
    send_request(FUNC_CHECK, 9'd2, '0);
    send_request(FUNC_CHECK, 9'd2, 16'd1);
    send_request(FUNC_SPARE, 9'd1, '0);
    send_request(FUNC_CHECK, 9'd1, '0);
    wait_drained();
  endtask

  // Drain the ring past its wrap, then allocate on a full table.
  task automatic test_table_full();
    while (free_slots != 0) send_request(FUNC_ALLOC, 9'($urandom_range(0, 511)), '0);
    send_request(FUNC_ALLOC, 9'h1FF, GenTop);
    send_request(FUNC_ALLOC, '0, '0);
    send_request(FUNC_CHECK, 9'd256, '0);
    send_request(FUNC_CHECK, 9'd2, 16'd1);
    wait_drained();
  endtask

  // Free and reallocate slot 1 so its generation climbs and it requeues.
  task automatic test_generation_churn();
    logic [GenW-1:0] gen;
    steady_flow = 1'b1;
    repeat (20) begin
      send_request(FUNC_FREE, 9'd1, slot_gen[0]);
      send_request(FUNC_ALLOC, 9'($urandom_range(0, 511)), 16'($urandom_range(0, 65535)));
    end
    gen = slot_gen[0];
    send_request(FUNC_CHECK, 9'd1, gen);
    send_request(FUNC_CHECK, 9'd1, gen - 16'd1);
    send_request(FUNC_FREE, 9'd1, gen);
    send_request(FUNC_ALLOC, '0, '0);
    send_request(FUNC_ALLOC, '0, '0);
    send_request(FUNC_CHECK, 9'd1, gen + 16'd1);
    wait_drained();
    steady_flow = 1'b0;
  endtask

  task automatic test_random_traffic();
    int unsigned roll;
    int unsigned s;
    logic [IndexW-1:0] idx;
    logic [GenW-1:0] gen;
    for (int n = 0; n < RandomRequests; n++) begin
      if (n == RandomRequests / 2) wait_drained();
      roll = $urandom_range(0, 99);
      s = pick_live_slot();
      if (s < Slots) begin
        idx = IndexW'(s + 1);
        gen = slot_gen[s];
      end else begin
        idx = '0;
        gen = '0;
      end
      if (roll < 30) begin
        send_request(FUNC_ALLOC, 9'($urandom_range(0, 511)), 16'($urandom_range(0, 65535)));
      end else if (roll < 65) begin
        send_request(FUNC_FREE, idx, gen);
      end else if (roll < 78) begin
        send_request(FUNC_CHECK, idx, gen);
      end else if (roll < 86) begin
        // stale generation on a live slot
        send_request(FuncW'($urandom_range(1, 2)), idx, gen ^ 16'($urandom_range(1, 65535)));
      end else if (roll < 95) begin
        send_request(FuncW'($urandom_range(0, 3)), 9'($urandom_range(0, 511)),
                     16'($urandom_range(0, 65535)));
      end else begin
        send_request(FUNC_SPARE, idx, gen);
      end
    end
    wait_drained();
  endtask

  always @(posedge clk_i) begin : result_check
    handle_outcome_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (awaited_outcomes.size() == 0) begin
        report_mismatch("result with nothing pending, index", 32'(out_index_o), '0);
      end else begin
        want = awaited_outcomes.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (out_index_o !== want.idx)
          report_mismatch("out_index", 32'(out_index_o), 32'(want.idx));
        if (out_generation_o !== want.gen)
          report_mismatch("out_generation", 32'(out_generation_o), 32'(want.gen));
        if (retired_o !== want.retired)
          report_mismatch("retired", 32'(retired_o), 32'(want.retired));
      end
    end
  end

  // Receiver back-pressure: switch among four stall styles, none while steady_flow is set.
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_style <= stall_style_e'($urandom_range(0, 3));
      stall_run <= $urandom_range(16, 96);
    end else begin
      stall_run <= stall_run - 1;
    end
    stall_phase <= stall_phase + 1'b1;
    if (steady_flow) begin
      out_stall_i <= 1'b0;
    end else begin
      case (stall_style)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 1) == 0);
        default:     out_stall_i <= (stall_phase[3:1] == 3'b111);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("generational_handle_allocator_core_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < Slots; i++) free_ring[i] = i;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_bad_handles();
    test_lifecycle();
    test_table_full();
    test_generation_churn();
    test_random_traffic();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && awaited_outcomes.size() == 0) begin
      $display("generational_handle_allocator_core_test: PASS");
    end else begin
      $display("generational_handle_allocator_core_test: FAIL");
    end
    $finish;
  end

endmodule
